>>> rtl/assert_macros.svh
// assertion macros shared by the timer rtl
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while rst is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every edge outside reset
`define ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mspet_pkg.sv
// shared types and codes for the periodic event timer
// no dependencies
package mspet_pkg;

   localparam int SLOTS_DEF = 8;

   typedef enum logic [2:0] {
      ACT_TICK        = 3'd0,
      ACT_REGISTER    = 3'd1,
      ACT_UNREGISTER  = 3'd2,
      ACT_ACTIVATE    = 3'd3,
      ACT_DEACTIVATE  = 3'd4,
      ACT_RESET_COUNT = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      KIND_EVENT = 2'd0,
      KIND_REPLY = 2'd1,
      KIND_ACK   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // one slot record as it travels along the ring
   typedef struct packed {
      logic [15:0] period;
      logic [15:0] count;
      logic        active;
   } rec_type;

   // per-step result of the head update
   typedef struct packed {
      logic fire;
      logic claim;
   } upd_stat_type;

endpackage

>>> rtl/multi_slot_periodic_event_timer.sv
// top level of the multi-slot periodic event timer
// depends on mspet_pkg, mspet_cell, mspet_upd and assert_macros.svh
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall   action, slot, period, start_active
//   rsp_      out         rsp_valid/rsp_stall   kind, slot_id, ok, uptime, last
//
// each request is captured, then makes one full turn of the slot ring past the
// head update, then finishes; an unknown action is taken in idle and dropped
// reset clears the slot ring, the uptime counter and all control state at once
// a tick holds back its latest event so the final one can carry last; a held
// event plus a new firing waits on rsp_stall, which freezes the ring rotation
module multi_slot_periodic_event_timer #(
   parameter int SLOTS = mspet_pkg::SLOTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [2:0]  req_slot,
   input  logic [15:0] req_period,
   input  logic        req_start_active,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_slot_id,
   output logic        rsp_ok,
   output logic [31:0] rsp_uptime,
   output logic        rsp_last
);
   import mspet_pkg::*;
   `include "assert_macros.svh"

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW    = ((IDX_W > 3) ? IDX_W : 3) + 1;

   // sequencer state
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   // captured request
   action_type  act_ff, act_in;
   logic [2:0]  slot_ff, slot_in;
   logic [15:0] period_ff, period_in;
   logic        start_ff, start_in;

   // register search result
   logic             found_ff, found_in;
   logic [IDX_W-1:0] handle_ff, handle_in;

   // event held back until the next firing or the end of the turn
   logic             held_v_ff, held_v_in;
   logic [IDX_W-1:0] held_id_ff, held_id_in;

   logic [31:0] uptime_ff, uptime_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    rsp_kind_ff, rsp_kind_in;
   logic [2:0]  rsp_slot_ff, rsp_slot_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic [31:0] rsp_uptime_ff, rsp_uptime_in;
   logic        rsp_last_ff, rsp_last_in;

   // ring wiring
   rec_type      ring_out [SLOTS];
   rec_type      ring_in  [SLOTS];
   rec_type      head_new;
   upd_stat_type stat;

   // control decode
   logic req_take;
   logic out_free;
   logic last_idx;
   logic is_tick;
   logic slot_match;
   logic exists;
   logic step;
   logic load_mid;
   logic load_final;
   logic uptime_inc;
   logic finish_done;

   assign req_take   = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_idx   = (idx_ff == IDX_W'(SLOTS - 1));
   assign is_tick    = (act_ff == ACT_TICK);
   assign slot_match = (CW'(idx_ff) == CW'(slot_ff));
   assign exists     = (CW'(slot_ff) < CW'(SLOTS));

   // ring of slot cells: each cell hands its record toward the head, the
   // updated head record re-enters at the tail
   genvar g;
   generate
      for (g = 0; g < SLOTS; g++) begin : g_ring
         if (g == SLOTS - 1) begin : g_tail
            assign ring_in[g] = head_new;
         end else begin : g_mid
            assign ring_in[g] = ring_out[g+1];
         end
         mspet_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (step),
            .rec_in   (ring_in[g]),
            .rec_out  (ring_out[g])
         );
      end
   endgenerate

   mspet_upd u_upd (
      .act        (act_ff),
      .slot_match (slot_match),
      .req_period (period_ff),
      .req_start  (start_ff),
      .found      (found_ff),
      .rec_in     (ring_out[0]),
      .rec_out    (head_new),
      .stat       (stat)
   );

   // finish completes once its result (if any) can go out
   assign finish_done = is_tick ? (!held_v_ff || out_free) : out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (action_type'(req_action)) inside
                  ACT_TICK, ACT_REGISTER, ACT_UNREGISTER,
                  ACT_ACTIVATE, ACT_DEACTIVATE, ACT_RESET_COUNT: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (step && last_idx) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall  = 1'b1;
      step       = 1'b0;
      load_mid   = 1'b0;
      load_final = 1'b0;
      uptime_inc = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_SCAN: begin
            // a second firing must push the held event out first
            step     = !(stat.fire && held_v_ff && !out_free);
            load_mid = stat.fire && held_v_ff && out_free;
         end
         ST_FINISH: begin
            load_final = out_free && (!is_tick || held_v_ff);
            uptime_inc = is_tick && finish_done;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      idx_in     = idx_ff;
      act_in     = act_ff;
      slot_in    = slot_ff;
      period_in  = period_ff;
      start_in   = start_ff;
      found_in   = found_ff;
      handle_in  = handle_ff;
      held_v_in  = held_v_ff;
      held_id_in = held_id_ff;
      uptime_in  = uptime_inc ? uptime_ff + 32'd1 : uptime_ff;

      if (req_take) begin
         act_in    = action_type'(req_action);
         slot_in   = req_slot;
         period_in = req_period;
         start_in  = req_start_active;
         found_in  = 1'b0;
         idx_in    = '0;
      end

      if (step) begin
         idx_in = last_idx ? '0 : idx_ff + IDX_W'(1);
         if (stat.claim) begin
            found_in  = 1'b1;
            handle_in = idx_ff;
         end
         if (stat.fire) begin
            held_v_in  = 1'b1;
            held_id_in = idx_ff;
         end
      end

      if (state_ff == ST_FINISH && is_tick && finish_done) begin
         held_v_in = 1'b0;
      end
   end

   // result register load
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_uptime_in = rsp_uptime_ff;
      rsp_last_in   = rsp_last_ff;
      if (load_mid || load_final) begin
         rsp_valid_in  = 1'b1;
         rsp_uptime_in = uptime_ff;
         rsp_last_in   = load_final;
         if (load_mid || is_tick) begin
            rsp_kind_in = KIND_EVENT;
            rsp_slot_in = 3'(held_id_ff);
            rsp_ok_in   = 1'b1;
         end else if (act_ff == ACT_REGISTER) begin
            rsp_kind_in = KIND_REPLY;
            rsp_slot_in = found_ff ? 3'(handle_ff) : 3'd0;
            rsp_ok_in   = found_ff;
         end else begin
            rsp_kind_in = KIND_ACK;
            rsp_slot_in = slot_ff;
            rsp_ok_in   = exists;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         held_v_ff    <= 1'b0;
         uptime_ff    <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         held_v_ff    <= held_v_in;
         uptime_ff    <= uptime_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      slot_ff       <= slot_in;
      period_ff     <= period_in;
      start_ff      <= start_in;
      handle_ff     <= handle_in;
      held_id_ff    <= held_id_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_uptime_ff <= rsp_uptime_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_slot_id = rsp_slot_ff;
   assign rsp_ok      = rsp_ok_ff;
   assign rsp_uptime  = rsp_uptime_ff;
   assign rsp_last    = rsp_last_ff;

   // a held event never survives into idle
   `ASSERT_IMP(a_held_not_idle, clock, reset, held_v_ff, state_ff != ST_IDLE, "held event in idle")
   // uptime only moves at the end of a tick, never mid-turn
   `ASSERT_NXT(a_uptime_scan, clock, reset, state_ff == ST_SCAN, $stable(uptime_ff), "uptime moved in scan")
   // an accepted tick starts a ring turn
   `ASSERT_NXT(a_tick_scans, clock, reset, req_take && req_action == ACT_TICK, state_ff == ST_SCAN, "tick did not scan")

endmodule

>>> rtl/mspet_cell.sv
// one slot cell of the rotating ring
// depends on mspet_pkg
module mspet_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  mspet_pkg::rec_type rec_in,
   output mspet_pkg::rec_type rec_out
);
   import mspet_pkg::*;

   rec_type rec_ff;
   rec_type rec_in_w;

   always_comb begin
      rec_in_w = shift_en ? rec_in : rec_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
      end else begin
         rec_ff <= rec_in_w;
      end
   end

   assign rec_out = rec_ff;

endmodule

>>> rtl/mspet_upd.sv
// update of the slot record at the head of the ring
// depends on mspet_pkg
module mspet_upd (
   input  mspet_pkg::action_type   act,
   input  logic                    slot_match,
   input  logic [15:0]             req_period,
   input  logic                    req_start,
   input  logic                    found,
   input  mspet_pkg::rec_type      rec_in,
   output mspet_pkg::rec_type      rec_out,
   output mspet_pkg::upd_stat_type stat
);
   import mspet_pkg::*;

   logic [15:0] count_inc;

   assign count_inc = rec_in.count + 16'd1;

   always_comb begin
      rec_out    = rec_in;
      stat       = '0;
      case (act)
         ACT_TICK: begin
            if (rec_in.period != 16'd0 && rec_in.active) begin
               if (count_inc >= rec_in.period) begin
                  rec_out.count = 16'd0;
                  stat.fire     = 1'b1;
               end else begin
                  rec_out.count = count_inc;
               end
            end
         end
         ACT_REGISTER: begin
            // first free slot in ascending order wins
            if (req_period != 16'd0 && !found && rec_in.period == 16'd0) begin
               rec_out.period = req_period;
               rec_out.count  = 16'd0;
               rec_out.active = req_start;
               stat.claim     = 1'b1;
            end
         end
         ACT_UNREGISTER: begin
            if (slot_match) begin
               rec_out = '0;
            end
         end
         ACT_ACTIVATE: begin
            if (slot_match) begin
               rec_out.active = 1'b1;
            end
         end
         ACT_DEACTIVATE: begin
            if (slot_match) begin
               rec_out.active = 1'b0;
            end
         end
         ACT_RESET_COUNT: begin
            if (slot_match) begin
               rec_out.count = 16'd0;
            end
         end
         default: begin
            rec_out = rec_in;
         end
      endcase
   end

endmodule
